### rtl/assert_macros.svh
// assertion macros shared by the rgb to cct and lux rtl
// expects clock aclk and active-low synchronous reset aresetn in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain clocked property, muted while in reset
`define ASSERT_AT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
    `ASSERT_AT(label, (ante) |-> (cons), msg)

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    `ASSERT_AT(label, (ante) |=> (cons), msg)

`endif

### rtl/cctl_pkg.sv
// shared types and constants for the rgb to cct and lux pipeline
// no dependencies
`default_nettype none

package cctl_pkg;

    // quotient width of the chromaticity and slope dividers (q4.20)
    localparam int Q_W    = 24;
    localparam int COEF_W = 18;
    localparam int FRAC_W = 20;

    // rgb to xyz matrix, signed q2.16
    localparam logic signed [COEF_W-1:0] MAT_COEF [0:2][0:2] = '{
        '{-18'sd9360,  18'sd101531, -18'sd62679},
        '{-18'sd21277, 18'sd103440, -18'sd47966},
        '{-18'sd44697, 18'sd50511,   18'sd36918}
    };

    // chromaticity reference points in q.20
    localparam logic signed [Q_W:0] XC_REF = 25'sd348127;
    localparam logic signed [Q_W:0] YC_REF = 25'sd194825;

    // cubic coefficients
    localparam logic signed [9:0]  CUBE_K   = 10'sd449;
    localparam logic signed [12:0] SQUARE_K = 13'sd3525;
    localparam logic signed [29:0] LIN_K    = 30'sd447171789;
    localparam logic signed [43:0] OFS_Q20  = 44'sd5788485550;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_ZERO = 2'd2
    } status_t;

    // side information carried along with each transaction
    typedef struct packed {
        logic [15:0] lux;
        logic        sat;
        logic        zero;
    } side_t;

endpackage

`default_nettype wire

### rtl/rgb_to_cct_and_lux_unit.sv
// rgb sensor counts to correlated color temperature (mccamy) and lux
// throughput: one transaction per cycle while m_ready does not stall the output
// the xc/yc divider pair then the slope divider, 26 stages each, set the depth
// later stages advance on a common enable; an empty front stage fills while stalled
// reset: synchronous active-low aresetn clears all valid bits, no payload is reset
// depends on cctl_pkg, cctl_div and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module rgb_to_cct_and_lux_unit import cctl_pkg::*; #(
    parameter int CHANNEL_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_red_count,
    input  wire logic [15:0] s_green_count,
    input  wire logic [15:0] s_blue_count,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_color_temp_kelvin,
    output logic [15:0]      m_lux_value,
    output logic [1:0]       m_status
);

    localparam int P_W  = COEF_W + CHANNEL_BITS + 1;
    localparam int T_W  = P_W + 2;
    localparam int S_W  = T_W + 2;
    localparam int AX_W = T_W + FRAC_W;
    localparam int SD_W = $bits(side_t);

    logic en;
    logic m_valid_reg;

    // global advance; the front stage may also fill a bubble while stalled
    assign en      = !m_valid_reg || m_ready;

    // stage 0: masked counts
    logic                    v0_reg;
    logic [CHANNEL_BITS-1:0] cnt_reg [0:2];

    assign s_ready = en || !v0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (s_ready) begin
            v0_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            cnt_reg[0] <= s_red_count[CHANNEL_BITS-1:0];
            cnt_reg[1] <= s_green_count[CHANNEL_BITS-1:0];
            cnt_reg[2] <= s_blue_count[CHANNEL_BITS-1:0];
        end
    end

    // stage 1: nine matrix products
    logic                  v1_reg;
    logic signed [P_W-1:0] prod_reg [0:2][0:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    prod_reg[i][j] <= MAT_COEF[i][j] * $signed({1'b0, cnt_reg[j]});
                end
            end
        end
    end

    // stage 2: tristimulus sums
    logic                  v2_reg;
    logic signed [T_W-1:0] t_reg [0:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                t_reg[i] <= T_W'(prod_reg[i][0]) + T_W'(prod_reg[i][1]) + T_W'(prod_reg[i][2]);
            end
        end
    end

    // stage 3: chromaticity operands and lux
    logic signed [63:0] lux_ext;
    logic [47:0]        lux_q;
    side_t              side3_next;

    assign lux_ext = 64'(t_reg[1]);
    assign lux_q   = 48'(lux_ext >>> 16);

    always_comb begin
        side3_next.zero = 1'b0;
        if (lux_ext[63]) begin
            side3_next.lux = '0;
            side3_next.sat = lux_ext <= -64'sd65536;
        end else if (lux_q[47:16] != '0) begin
            side3_next.lux = 16'hFFFF;
            side3_next.sat = 1'b1;
        end else begin
            side3_next.lux = lux_q[15:0];
            side3_next.sat = 1'b0;
        end
    end

    logic                   v3_reg;
    logic signed [AX_W-1:0] ax_reg;
    logic signed [AX_W-1:0] ay_reg;
    logic signed [S_W-1:0]  s_reg;
    side_t                  side3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ax_reg    <= {t_reg[0], {FRAC_W{1'b0}}};
            ay_reg    <= {t_reg[1], {FRAC_W{1'b0}}};
            s_reg     <= S_W'(t_reg[0]) + S_W'(t_reg[1]) + S_W'(t_reg[2]);
            side3_reg <= side3_next;
        end
    end

    // xc and yc dividers
    logic                  va_valid;
    logic signed [Q_W-1:0] xc;
    logic signed [Q_W-1:0] yc;
    logic                  xc_sat;
    logic                  yc_sat;
    logic                  sum_zero;
    logic [SD_W-1:0]       side_a_vec;

    cctl_div #(.AW(AX_W), .BW(S_W), .SW(SD_W)) u_div_xc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v3_reg),
        .a         (ax_reg),
        .b         (s_reg),
        .side_in   (side3_reg),
        .out_valid (va_valid),
        .quo       (xc),
        .sat       (xc_sat),
        .zero      (sum_zero),
        .side_out  (side_a_vec)
    );

    cctl_div #(.AW(AX_W), .BW(S_W), .SW(1)) u_div_yc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v3_reg),
        .a         (ay_reg),
        .b         (s_reg),
        .side_in   (1'b0),
        .out_valid (),
        .quo       (yc),
        .sat       (yc_sat),
        .zero      (),
        .side_out  ()
    );

    // stage 4: slope numerator and denominator
    side_t side_a;
    side_t side4_next;

    assign side_a = side_a_vec;

    always_comb begin
        side4_next      = side_a;
        side4_next.zero = sum_zero;
        side4_next.sat  = side_a.sat | xc_sat | yc_sat;
    end

    logic                v4_reg;
    logic signed [Q_W:0] num_reg;
    logic signed [Q_W:0] den_reg;
    side_t               side4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= va_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg   <= (Q_W+1)'(xc) - XC_REF;
            den_reg   <= YC_REF - (Q_W+1)'(yc);
            side4_reg <= side4_next;
        end
    end

    // slope divider
    logic                  vb_valid;
    logic signed [Q_W-1:0] n_val;
    logic                  n_sat;
    logic                  den_zero;
    logic [SD_W-1:0]       side_b_vec;

    cctl_div #(.AW(Q_W+1+FRAC_W), .BW(Q_W+1), .SW(SD_W)) u_div_n (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v4_reg),
        .a         ({num_reg, {FRAC_W{1'b0}}}),
        .b         (den_reg),
        .side_in   (side4_reg),
        .out_valid (vb_valid),
        .quo       (n_val),
        .sat       (n_sat),
        .zero      (den_zero),
        .side_out  (side_b_vec)
    );

    side_t side_b;
    side_t side5_next;

    assign side_b = side_b_vec;

    always_comb begin
        side5_next      = side_b;
        side5_next.zero = side_b.zero | den_zero;
        side5_next.sat  = side_b.sat | n_sat;
    end

    // stage 5: n squared and linear product
    logic                  v5_reg;
    logic signed [47:0]    nn_reg;
    logic signed [53:0]    linp_reg;
    logic signed [Q_W-1:0] n_reg;
    side_t                 side5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= vb_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nn_reg    <= n_val * n_val;
            linp_reg  <= LIN_K * n_val;
            n_reg     <= n_val;
            side5_reg <= side5_next;
        end
    end

    // stage 6: n2, n2*n and scaled linear term
    logic signed [27:0] n2_next;

    assign n2_next = nn_reg[47:20];

    logic               v6_reg;
    logic signed [27:0] n2_reg;
    logic signed [51:0] n3p_reg;
    logic signed [37:0] lin_reg;
    side_t              side6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (en) begin
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n2_reg    <= n2_next;
            n3p_reg   <= n2_next * n_reg;
            lin_reg   <= 38'((linp_reg + (linp_reg[53] ? 54'sd65535 : 54'sd0)) >>> 16);
            side6_reg <= side5_reg;
        end
    end

    // stage 7: n3 truncated toward zero
    logic               v7_reg;
    logic signed [31:0] n3_reg;
    logic signed [27:0] n2_d_reg;
    logic signed [37:0] lin_d_reg;
    side_t              side7_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v7_reg <= 1'b0;
        end else if (en) begin
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n3_reg    <= 32'((n3p_reg + (n3p_reg[51] ? 52'sd1048575 : 52'sd0)) >>> 20);
            n2_d_reg  <= n2_reg;
            lin_d_reg <= lin_reg;
            side7_reg <= side6_reg;
        end
    end

    // stage 8: cubic and square terms
    logic               v8_reg;
    logic signed [41:0] cube_reg;
    logic signed [40:0] square_reg;
    logic signed [37:0] lin_e_reg;
    side_t              side8_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v8_reg <= 1'b0;
        end else if (en) begin
            v8_reg <= v7_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cube_reg   <= CUBE_K * n3_reg;
            square_reg <= SQUARE_K * n2_d_reg;
            lin_e_reg  <= lin_d_reg;
            side8_reg  <= side7_reg;
        end
    end

    // stage 9: temperature sum in q.20
    logic               v9_reg;
    logic signed [43:0] cct_reg;
    side_t              side9_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v9_reg <= 1'b0;
        end else if (en) begin
            v9_reg <= v8_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cct_reg   <= 44'(cube_reg) + 44'(square_reg) + 44'(lin_e_reg) + OFS_Q20;
            side9_reg <= side8_reg;
        end
    end

    // output stage: kelvin clamp and status
    logic [15:0] kel_next;
    logic        kel_sat;
    status_t     status_next;

    always_comb begin
        if (cct_reg[43]) begin
            kel_next = '0;
            kel_sat  = cct_reg <= -44'sd1048576;
        end else if (cct_reg[42:36] != '0) begin
            kel_next = 16'hFFFF;
            kel_sat  = 1'b1;
        end else begin
            kel_next = cct_reg[35:20];
            kel_sat  = 1'b0;
        end
        if (side9_reg.zero) begin
            status_next = ST_ZERO;
            kel_next    = '0;
        end else if (side9_reg.sat || kel_sat) begin
            status_next = ST_SAT;
        end else begin
            status_next = ST_OK;
        end
    end

    logic [15:0] kel_reg;
    logic [15:0] lux_reg;
    status_t     status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= v9_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            kel_reg    <= kel_next;
            lux_reg    <= side9_reg.lux;
            status_reg <= status_next;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_color_temp_kelvin = kel_reg;
    assign m_lux_value         = lux_reg;
    assign m_status            = status_reg;

    // zero denominator always reports zero kelvin
    `ASSERT_IMPL(a_zero_kelvin, m_valid_reg && (status_reg == ST_ZERO), kel_reg == '0, "zero status with nonzero kelvin")
    // a stalled front stage holds its transaction
    `ASSERT_NEXT(a_front_hold, v0_reg && !en, v0_reg && $stable(cnt_reg[0]), "front stage lost a transaction while stalled")

endmodule

`default_nettype wire

### rtl/cctl_div.sv
// pipelined signed restoring divider, one quotient bit per stage, saturating q4.20 result
// depends on cctl_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module cctl_div import cctl_pkg::*; #(
    parameter int AW = 56,
    parameter int BW = 38,
    parameter int SW = 18
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire logic signed [AW-1:0] a,
    input  wire logic signed [BW-1:0] b,
    input  wire logic [SW-1:0]        side_in,
    output logic                      out_valid,
    output logic signed [Q_W-1:0]     quo,
    output logic                      sat,
    output logic                      zero,
    output logic [SW-1:0]             side_out
);

    localparam int CW = (AW > BW + Q_W) ? AW : BW + Q_W;
    localparam logic [Q_W-1:0] POS_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic [Q_W-1:0] NEG_MAG = {1'b1, {(Q_W-1){1'b0}}};

    logic [CW-1:0]  rem_reg  [0:Q_W];
    logic [BW-1:0]  bmag_reg [0:Q_W];
    logic [Q_W-1:0] q_reg    [0:Q_W];
    logic           neg_reg  [0:Q_W];
    logic           ovf_reg  [0:Q_W];
    logic           zero_reg [0:Q_W];
    logic           vld_reg  [0:Q_W];
    logic [SW-1:0]  side_reg [0:Q_W];

    logic [AW-1:0] amag;
    logic [BW-1:0] bmag;
    logic          ovf_next;

    // magnitudes and quotient overflow check
    assign amag     = a[AW-1] ? AW'(-a) : AW'(a);
    assign bmag     = b[BW-1] ? BW'(-b) : BW'(b);
    assign ovf_next = CW'(amag) >= CW'({bmag, {Q_W{1'b0}}});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= CW'(amag);
            bmag_reg[0] <= bmag;
            q_reg[0]    <= '0;
            neg_reg[0]  <= a[AW-1] ^ b[BW-1];
            ovf_reg[0]  <= ovf_next;
            zero_reg[0] <= (b == '0);
            side_reg[0] <= side_in;
        end
    end

    // one trial subtraction per stage, msb first
    for (genvar j = 0; j < Q_W; j++) begin : g_step
        localparam int K = Q_W - 1 - j;
        logic [CW:0] diff;
        logic        take;

        assign diff = {1'b0, rem_reg[j]} - ((CW+1)'(bmag_reg[j]) << K);
        assign take = ~diff[CW];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j+1] <= 1'b0;
            end else if (en) begin
                vld_reg[j+1] <= vld_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j+1]  <= take ? diff[CW-1:0] : rem_reg[j];
                q_reg[j+1]    <= q_reg[j] | (Q_W'(take) << K);
                bmag_reg[j+1] <= bmag_reg[j];
                neg_reg[j+1]  <= neg_reg[j];
                ovf_reg[j+1]  <= ovf_reg[j];
                zero_reg[j+1] <= zero_reg[j];
                side_reg[j+1] <= side_reg[j];
            end
        end
    end

    logic [Q_W-1:0] q_fin;
    logic [Q_W-1:0] quo_next;
    logic           sat_next;

    // sign and clamp to q4.20 range
    assign q_fin = q_reg[Q_W];

    always_comb begin
        if (ovf_reg[Q_W]) begin
            sat_next = 1'b1;
            quo_next = neg_reg[Q_W] ? NEG_MAG : POS_MAX;
        end else if (!neg_reg[Q_W]) begin
            sat_next = q_fin[Q_W-1];
            quo_next = sat_next ? POS_MAX : q_fin;
        end else begin
            sat_next = q_fin > NEG_MAG;
            quo_next = sat_next ? NEG_MAG : Q_W'(-q_fin);
        end
    end

    logic                 out_valid_reg;
    logic signed [Q_W-1:0] quo_reg;
    logic                 sat_reg;
    logic                 zero_out_reg;
    logic [SW-1:0]        side_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= vld_reg[Q_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quo_reg      <= quo_next;
            sat_reg      <= sat_next;
            zero_out_reg <= zero_reg[Q_W];
            side_out_reg <= side_reg[Q_W];
        end
    end

    assign out_valid = out_valid_reg;
    assign quo       = quo_reg;
    assign sat       = sat_reg;
    assign zero      = zero_out_reg;
    assign side_out  = side_out_reg;

    // remainder must end below the divisor when no overflow was flagged
    `ASSERT_IMPL(a_div_rem_bound, vld_reg[Q_W] && !ovf_reg[Q_W], rem_reg[Q_W] < CW'(bmag_reg[Q_W]), "divider remainder not below divisor")
    // a zero divisor always takes the overflow path
    `ASSERT_IMPL(a_div_zero_ovf, vld_reg[0] && zero_reg[0], ovf_reg[0], "zero divisor without overflow")

endmodule

`default_nettype wire
